// ===== src/tx_ring_segment_queue_unit_defines.svh =====
// Assertion macros for the tx ring segment queue checker.
// Depends on nothing; included by the checker file by bare name.
`ifndef TX_RING_SEGMENT_QUEUE_UNIT_DEFINES_SVH
`define TX_RING_SEGMENT_QUEUE_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define TRSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TRSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/trsq_pkg.sv =====
// Shared types and codes of the tx ring segment queue.
// No dependencies; used by the top level and the checker.
`default_nettype none

package trsq_pkg;

	// func codes of an input transfer
	localparam logic [1:0] FUNC_BYTE  = 2'd0;
	localparam logic [1:0] FUNC_DONE  = 2'd1;
	localparam logic [1:0] FUNC_ERR   = 2'd2;
	localparam logic [1:0] FUNC_FETCH = 2'd3;

	// kind codes of a result transfer
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_SEG    = 2'd1;
	localparam logic [1:0] KIND_FETCH  = 2'd2;

	localparam int FIELD_W = 11;  // seg_addr, seg_len, fetch_addr
	localparam int LEN_W   = 12;  // msg_len
	localparam int BYTE_W  = 8;

	// result queue between the update logic and the output port
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;
	localparam int RQ_CW    = 3;

	typedef struct packed {
		logic [1:0]         kind;
		logic               write_ok;
		logic [FIELD_W-1:0] seg_addr;
		logic [FIELD_W-1:0] seg_len;
		logic [BYTE_W-1:0]  data_out;
		logic               last;
	} res_t;

endpackage

`default_nettype wire

// ===== src/trsq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module trsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/tx_ring_segment_queue_unit.sv =====
// Top level of the tx ring segment queue: pointer logic, result stage and queue.
// Depends on trsq_pkg and trsq_ram.
//
// Channel  Dir  Fields (tdata / tuser / tlast)
// s_*      in   tdata: data_byte, msg_len, fetch_addr; tuser: func, first_of_msg
// m_*      out  tdata: write_ok, seg_addr, seg_len, data_out; tuser: kind; tlast: last
//
// One input transfer per cycle is taken while the result stage and the four-entry
// result queue hold at most two results; one result leaves per cycle while m_tready
// is high, so an item with two results (write status plus segment start) leaves as
// two output transfers. Each result is registered in the result stage, with the
// ring RAM read, then in the result queue. Reset is asynchronous and clears the
// pointers and queue control; the ring RAM has no clearing pass and is not reset.
// A stall on m_* holds the result in the queue; s_tready closes past two results.
`default_nettype none

module tx_ring_segment_queue_unit #(
	parameter int ADDR_W = 11  // ring depth is 2**ADDR_W, 2 to 11
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [31:0] s_tdata,   // [7:0] data_byte, [19:8] msg_len, [30:20] fetch_addr
	input  wire logic [2:0]  s_tuser,   // [1:0] func, [2] first_of_msg
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // [0] write_ok, [11:1] seg_addr, [22:12] seg_len,
	                                    // [30:23] data_out
	output      logic [1:0]  m_tuser,   // [1:0] kind
	output      logic        m_tlast
);

	localparam int DEPTH = 1 << ADDR_W;
	localparam int CW    = (ADDR_W + 1 > trsq_pkg::LEN_W) ? ADDR_W + 1 : trsq_pkg::LEN_W;
	localparam int FW    = trsq_pkg::FIELD_W;

	// Unpack the input transfer
	logic [1:0]                  func;
	logic                        first_of_msg;
	logic [trsq_pkg::BYTE_W-1:0] data_byte;
	logic [trsq_pkg::LEN_W-1:0]  msg_len;
	logic [FW-1:0]               fetch_addr;

	assign func         = s_tuser[1:0];
	assign first_of_msg = s_tuser[2];
	assign data_byte    = s_tdata[7:0];
	assign msg_len      = s_tdata[19:8];
	assign fetch_addr   = s_tdata[30:20];

	logic in_xfer;
	assign in_xfer = s_tvalid && s_tready;

	// Ring state
	logic [ADDR_W-1:0] head_q, tail_q, active_q, wptr_q, left_q;
	logic              sending_q, dropping_q;

	logic [ADDR_W-1:0] head_d, tail_d, active_d, wptr_d, left_d;
	logic              sending_d, dropping_d;

	// Ring RAM port
	logic                        ram_we, ram_re;
	logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
	logic [trsq_pkg::BYTE_W-1:0] ram_rdata;

	// Results of the current transfer
	trsq_pkg::res_t res0, res1;
	logic           res0_v, res1_v, res_fetch;

	// Admission check on a first byte
	logic [ADDR_W-1:0] used_a, free_a;
	logic [CW-1:0]     len_w, free_w;
	logic              reject;

	assign used_a = head_q - tail_q;
	assign free_a = ~used_a;
	assign len_w  = CW'(msg_len);
	assign free_w = CW'(free_a);
	assign reject = (msg_len == '0) || (len_w >= CW'(DEPTH)) || (len_w > free_w);

	// Fetch offset wraps on the ring depth
	logic [ADDR_W+FW-1:0] fetch_ext;
	assign fetch_ext = {{ADDR_W{1'b0}}, fetch_addr};
	assign ram_raddr = fetch_ext[ADDR_W-1:0];

	// Segment candidate
	logic [ADDR_W-1:0]    h_c, t_c;
	logic                 s_c, try_start, start;
	logic [ADDR_W:0]      seg_w;
	logic [ADDR_W+FW-1:0] seg_addr_ext, seg_len_ext;

	// Byte store
	logic              store;
	logic [ADDR_W-1:0] wptr_eff, left_eff, wptr_inc;

	assign wptr_inc = wptr_eff + 1'b1;

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		active_d   = active_q;
		sending_d  = sending_q;
		wptr_d     = wptr_q;
		left_d     = left_q;
		dropping_d = dropping_q;
		store      = 1'b0;
		wptr_eff   = wptr_q;
		left_eff   = left_q;
		ram_we     = 1'b0;
		ram_waddr  = wptr_q;
		ram_re     = 1'b0;
		res0       = '0;
		res1       = '0;
		res0_v     = 1'b0;
		res1_v     = 1'b0;
		res_fetch  = 1'b0;
		h_c        = head_q;
		t_c        = tail_q;
		s_c        = sending_q;
		try_start  = 1'b0;

		unique case (func)
			trsq_pkg::FUNC_BYTE: begin
				if (first_of_msg) begin
					if (reject) begin
						// Reject whole message; drop its bytes until the next first byte
						dropping_d    = 1'b1;
						left_d        = '0;
						res0.kind     = trsq_pkg::KIND_STATUS;
						res0.write_ok = 1'b0;
						res0_v        = 1'b1;
					end else begin
						dropping_d = 1'b0;
						store      = 1'b1;
						wptr_eff   = head_q;
						left_eff   = msg_len[ADDR_W-1:0];
					end
				end else if (!dropping_q && left_q != '0) begin
					store = 1'b1;
				end
			end
			trsq_pkg::FUNC_DONE: begin
				if (sending_q) begin
					t_c       = tail_q + active_q;
					s_c       = 1'b0;
					try_start = 1'b1;
				end
			end
			trsq_pkg::FUNC_ERR: begin
				if (sending_q) begin
					t_c = tail_q + active_q;
					s_c = 1'b0;
				end
				try_start = 1'b1;
			end
			trsq_pkg::FUNC_FETCH: begin
				ram_re    = 1'b1;
				res0.kind = trsq_pkg::KIND_FETCH;
				res0_v    = 1'b1;
				res_fetch = 1'b1;
			end
		endcase

		if (store) begin
			ram_we    = 1'b1;
			ram_waddr = wptr_eff;
			wptr_d    = wptr_inc;
			left_d    = left_eff - 1'b1;
			if (left_eff == ADDR_W'(1)) begin
				// Commit the message: advance head and report success
				head_d        = wptr_inc;
				h_c           = wptr_inc;
				res0.kind     = trsq_pkg::KIND_STATUS;
				res0.write_ok = 1'b1;
				res0_v        = 1'b1;
				try_start     = 1'b1;
			end
		end

		tail_d = t_c;
		sending_d = s_c;

		// Segment runs up to head, or up to the ring end when the data wraps
		start = try_start && !s_c && (h_c != t_c);
		if (h_c > t_c) begin
			seg_w = {1'b0, h_c} - {1'b0, t_c};
		end else begin
			seg_w = (ADDR_W + 1)'(DEPTH) - {1'b0, t_c};
		end
		seg_addr_ext = {{FW{1'b0}}, t_c};
		seg_len_ext  = {{FW{1'b0}}, seg_w[ADDR_W-1:0]};

		if (start) begin
			sending_d = 1'b1;
			active_d  = seg_w[ADDR_W-1:0];
			if (res0_v) begin
				res1.kind     = trsq_pkg::KIND_SEG;
				res1.seg_addr = seg_addr_ext[FW-1:0];
				res1.seg_len  = seg_len_ext[FW-1:0];
				res1_v        = 1'b1;
			end else begin
				res0.kind     = trsq_pkg::KIND_SEG;
				res0.seg_addr = seg_addr_ext[FW-1:0];
				res0.seg_len  = seg_len_ext[FW-1:0];
				res0_v        = 1'b1;
			end
		end

		res0.last = !res1_v;
		res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			active_q   <= '0;
			sending_q  <= 1'b0;
			wptr_q     <= '0;
			left_q     <= '0;
			dropping_q <= 1'b0;
		end else if (in_xfer) begin
			head_q     <= head_d;
			tail_q     <= tail_d;
			active_q   <= active_d;
			sending_q  <= sending_d;
			wptr_q     <= wptr_d;
			left_q     <= left_d;
			dropping_q <= dropping_d;
		end
	end

	trsq_ram #(
		.WIDTH (trsq_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (in_xfer && ram_we),
		.waddr (ram_waddr),
		.wdata (data_byte),
		.re    (in_xfer && ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result stage: registered alongside the RAM read, whose data fills a fetch result
	trsq_pkg::res_t res0_s1, res1_s1, res0_fix;
	logic           v0_s1, v1_s1, fetch_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_s1 <= 1'b0;
			v1_s1 <= 1'b0;
		end else begin
			v0_s1 <= in_xfer && res0_v;
			v1_s1 <= in_xfer && res1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res0_s1  <= res0;
			res1_s1  <= res1;
			fetch_s1 <= res_fetch;
		end
	end

	always_comb begin
		res0_fix = res0_s1;
		if (fetch_s1) begin
			res0_fix.data_out = ram_rdata;
		end
	end

	// Result queue
	trsq_pkg::res_t             rq_q [trsq_pkg::RQ_DEPTH];
	logic [trsq_pkg::RQ_AW-1:0] rq_wr_q, rq_rd_q, rq_wr_inc;
	logic [trsq_pkg::RQ_CW-1:0] rq_cnt_q, occ, push_n;
	logic                       pop;
	trsq_pkg::res_t             rq_head;

	assign rq_wr_inc = rq_wr_q + 1'b1;
	assign push_n    = {2'b00, v0_s1} + {2'b00, v1_s1};
	assign occ       = rq_cnt_q + push_n;
	assign s_tready  = (occ <= trsq_pkg::RQ_CW'(2));
	assign pop       = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (v0_s1) begin
			rq_q[rq_wr_q] <= res0_fix;
		end
		if (v1_s1) begin
			rq_q[rq_wr_inc] <= res1_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			rq_wr_q  <= rq_wr_q + push_n[trsq_pkg::RQ_AW-1:0];
			rq_cnt_q <= occ - {2'b00, pop};
			if (pop) begin
				rq_rd_q <= rq_rd_q + 1'b1;
			end
		end
	end

	assign rq_head  = rq_q[rq_rd_q];
	assign m_tvalid = (rq_cnt_q != '0);
	assign m_tdata  = {1'b0, rq_head.data_out, rq_head.seg_len, rq_head.seg_addr,
	                   rq_head.write_ok};
	assign m_tuser  = rq_head.kind;
	assign m_tlast  = rq_head.last;

endmodule

`default_nettype wire

// ===== src/trsq_checker.sv =====
// Port-level checker for the tx ring segment queue, bound to the top level.
// Depends on trsq_pkg and tx_ring_segment_queue_unit_defines.svh.
`default_nettype none
`include "tx_ring_segment_queue_unit_defines.svh"

module trsq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	logic [34:0] m_word;
	logic        m_stall, m_xfer, end_kind, is_seg, rej_stat;

	assign m_word   = {m_tlast, m_tuser, m_tdata};
	assign m_stall  = m_tvalid && !m_tready;
	assign m_xfer   = m_tvalid && m_tready;
	assign is_seg   = (m_tuser == trsq_pkg::KIND_SEG);
	assign end_kind = (m_tuser == trsq_pkg::KIND_FETCH) || is_seg;
	assign rej_stat = (m_tuser == trsq_pkg::KIND_STATUS) && !m_tdata[0];

	// hold a stalled result
	`TRSQ_ASSERT(a_m_hold, clk, arst_n, m_stall |=> m_tvalid && $stable(m_word), "result moved")

	// no result shows once reset has been seen
	`TRSQ_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !m_tvalid, "result valid in reset")

	// a fetch or a segment start always ends its item's results
	`TRSQ_ASSERT(a_end_kinds, clk, arst_n, m_tvalid && end_kind |-> m_tlast, "end kind not last")

	// a rejected message reports alone
	`TRSQ_ASSERT(a_reject_last, clk, arst_n, m_tvalid && rej_stat |-> m_tlast, "reject not last")

	// an unfinished item leaves a segment start right behind it
	`TRSQ_ASSERT(a_pair, clk, arst_n, m_xfer && !m_tlast |=> m_tvalid && is_seg, "no segment")

endmodule

bind tx_ring_segment_queue_unit trsq_checker u_trsq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
